### rtl/tck_pkg.sv
// Shared types, constants and command words for the two-channel scalar Kalman filter.
`timescale 1ns / 1ps

package tck_pkg;

  // Default sizes, handed down from the top level
  localparam int CHANNELS_DEF   = 2;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed-point format and register file
  localparam int FRAC_BITS = 16;
  localparam int GAIN_BITS = FRAC_BITS + 1;
  localparam int CFG_BITS  = 32;
  localparam int ADDR_BITS = 3;
  localparam int DIV_STEPS = FRAC_BITS;
  localparam int STEP_BITS = $clog2(DIV_STEPS);

  localparam logic [GAIN_BITS-1:0] ONE_FIX  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [CFG_BITS-1:0]  Q_RESET  = 32'd655;
  localparam logic [CFG_BITS-1:0]  R_RESET  = 32'd65536;

  // Item kinds; the unused code behaves as a forecast
  typedef enum logic [1:0] {
    KIND_FCAST  = 2'd0,
    KIND_FILTER = 2'd1,
    KIND_RESET  = 2'd2
  } kind_t;

  // Register indexes
  typedef enum logic {
    REG_Q = 1'b0,
    REG_R = 1'b1
  } reg_idx_t;

  // Controller to datapath
  typedef struct packed {
    logic latch_in;  // capture the observations of an accepted word
    logic fcast;     // forecast every channel
    logic clear;     // clear channel state ahead of the forecast
    logic div_init;  // load divider and difference for the current channel
    logic div_step;  // one restoring division step
    logic mul_est;   // multiply gain by the innovation magnitude
    logic mul_cov;   // multiply (1 - gain) by the covariance, write estimate
    logic cov_wr;    // write the updated covariance
    logic out_load;  // load the output register
    logic out_filt;  // output filtered estimates instead of predictions
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_last;  // last division step this cycle
  } stat_t;

endpackage

### rtl/tck_regs.sv
// APB-style register file holding the process and measurement noise variances.
`timescale 1ns / 1ps

module tck_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tck_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [tck_pkg::CFG_BITS-1:0]   pwdata,
  output logic [tck_pkg::CFG_BITS-1:0]   prdata,
  output logic                           pready,
  output logic [tck_pkg::CFG_BITS-1:0]   q_var,
  output logic [tck_pkg::CFG_BITS-1:0]   r_var
);
  import tck_pkg::*;

  logic [CFG_BITS-1:0] q_r;
  logic [CFG_BITS-1:0] r_r;
  reg_idx_t            idx;

  assign idx    = reg_idx_t'(paddr[ADDR_BITS-1]);
  assign pready = 1'b1;
  assign q_var  = q_r;
  assign r_var  = r_r;

  // Write on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= Q_RESET;
      r_r <= R_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_Q:   q_r <= pwdata;
        REG_R:   r_r <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_Q:   prdata = q_r;
      REG_R:   prdata = r_r;
      default: prdata = '0;
    endcase
  end

endmodule

### rtl/tck_ctrl.sv
// Sequencer: accepts words, steps each channel through divide and multiply, loads the result.
`timescale 1ns / 1ps

module tck_ctrl #(
  parameter int CHANNELS = tck_pkg::CHANNELS_DEF,
  parameter int CW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [1:0]     in_kind,
  output logic           in_ready,
  input  logic           out_ready,
  output logic           out_valid,
  input  tck_pkg::stat_t stat,
  output logic [CW-1:0]  ch,
  output tck_pkg::cmd_t  cmd
);
  import tck_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FCAST,
    S_DINIT,
    S_DSTEP,
    S_MEST,
    S_MCOV,
    S_CWR,
    S_LOAD
  } state_t;

  localparam logic [CW-1:0] LAST_CH = CW'(CHANNELS - 1);

  state_t        state_r;
  logic          out_valid_r;
  logic [CW-1:0] ch_r;
  logic          filt_r;
  logic          clear_r;
  logic          load_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign ch        = ch_r;
  assign load_ok   = !out_valid_r || out_ready;

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      ch_r        <= '0;
      filt_r      <= 1'b0;
      clear_r     <= 1'b0;
    end else begin
      // raise on load, drop once taken
      if ((state_r == S_LOAD) && load_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            ch_r    <= '0;
            filt_r  <= (in_kind == KIND_FILTER);
            clear_r <= (in_kind == KIND_RESET);
            state_r <= (in_kind == KIND_FILTER) ? S_DINIT : S_FCAST;
          end
        end
        S_FCAST: state_r <= S_LOAD;
        S_DINIT: state_r <= S_DSTEP;
        S_DSTEP: begin
          if (stat.div_last) state_r <= S_MEST;
        end
        S_MEST:  state_r <= S_MCOV;
        S_MCOV:  state_r <= S_CWR;
        S_CWR: begin
          if (ch_r == LAST_CH) begin
            state_r <= S_LOAD;
          end else begin
            ch_r    <= ch_r + CW'(1);
            state_r <= S_DINIT;
          end
        end
        S_LOAD: begin
          // hold the result until the output register is free
          if (load_ok) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Decode commands from the state
  always_comb begin
    cmd          = '0;
    cmd.latch_in = (state_r == S_IDLE) && in_valid;
    cmd.fcast    = (state_r == S_FCAST);
    cmd.clear    = clear_r;
    cmd.div_init = (state_r == S_DINIT);
    cmd.div_step = (state_r == S_DSTEP);
    cmd.mul_est  = (state_r == S_MEST);
    cmd.mul_cov  = (state_r == S_MCOV);
    cmd.cov_wr   = (state_r == S_CWR);
    cmd.out_load = (state_r == S_LOAD) && load_ok;
    cmd.out_filt = filt_r;
  end

endmodule

### rtl/tck_dp.sv
// Datapath: channel state, forecast adders, restoring gain divider, shared multiplier.
`timescale 1ns / 1ps

module tck_dp #(
  parameter int CHANNELS   = tck_pkg::CHANNELS_DEF,
  parameter int VALUE_BITS = tck_pkg::VALUE_BITS_DEF,
  parameter int CW         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tck_pkg::cmd_t                 cmd,
  output tck_pkg::stat_t                stat,
  input  logic [CW-1:0]                 ch,
  input  logic signed [VALUE_BITS-1:0]  in_obs_x,
  input  logic signed [VALUE_BITS-1:0]  in_obs_y,
  input  logic [tck_pkg::CFG_BITS-1:0]  q_var,
  input  logic [tck_pkg::CFG_BITS-1:0]  r_var,
  output logic signed [VALUE_BITS-1:0]  out_est_x,
  output logic signed [VALUE_BITS-1:0]  out_est_y
);
  import tck_pkg::*;

  localparam int VB    = VALUE_BITS;
  localparam int SW    = ((VB > CFG_BITS) ? VB : CFG_BITS) + 1;  // exact sums
  localparam int MW    = VB + 1;                                 // innovation magnitude
  localparam int PW    = GAIN_BITS + MW;                         // product
  localparam int Y_IDX = (CHANNELS > 1) ? 1 : 0;

  localparam logic [PW-1:0]          HALF   = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [VB+1:0]   SMAX_W = {3'b000, {(VB-1){1'b1}}};
  localparam logic signed [VB+1:0]   SMIN_W = {3'b111, {(VB-1){1'b0}}};

  // Channel state
  logic signed [VB-1:0] est_r  [CHANNELS];
  logic        [VB-1:0] cov_r  [CHANNELS];
  logic signed [VB-1:0] pest_r [CHANNELS];
  logic        [VB-1:0] pcov_r [CHANNELS];

  // Per-item working registers
  logic signed [VB-1:0]    obs_x_r;
  logic signed [VB-1:0]    obs_y_r;
  logic signed [VB-1:0]    xp_r;
  logic [VB-1:0]           pp_r;
  logic [MW-1:0]           mag_r;
  logic                    neg_r;
  logic [SW-1:0]           den_r;
  logic [SW-1:0]           rem_r;
  logic [GAIN_BITS-1:0]    q_r;
  logic                    den_zero_r;
  logic [STEP_BITS-1:0]    step_r;
  logic [PW-1:0]           prod_r;
  logic signed [VB-1:0]    out_x_r;
  logic signed [VB-1:0]    out_y_r;

  logic signed [VB-1:0]    pest_sel;
  logic [VB-1:0]           pcov_sel;
  logic signed [VB-1:0]    z_sel;
  logic [MW-1:0]           diff_u;
  logic [SW:0]             rem_sh;
  logic                    fit;
  logic [SW-1:0]           rem_nxt;
  logic [GAIN_BITS-1:0]    q_nxt;
  logic [GAIN_BITS-1:0]    gain;
  logic [GAIN_BITS-1:0]    mul_a;
  logic [MW-1:0]           mul_b;
  logic [PW-1:0]           rnd_w;
  logic signed [VB+1:0]    xp_w;
  logic signed [VB+1:0]    rnd_e;
  logic signed [VB+1:0]    x_w;
  logic signed [VB-1:0]    x_new;
  logic [SW-1:0]           fc_sum [CHANNELS];
  logic [VB-1:0]           fc_cov [CHANNELS];

  assign pest_sel = pest_r[ch];
  assign pcov_sel = pcov_r[ch];
  assign z_sel    = (ch == '0) ? obs_x_r : obs_y_r;

  // Innovation and its magnitude
  assign diff_u = {z_sel[VB-1], z_sel} - {pest_sel[VB-1], pest_sel};

  // Restoring division step
  assign rem_sh  = {rem_r, 1'b0};
  assign fit     = (rem_sh >= {1'b0, den_r});
  assign rem_nxt = fit ? SW'(rem_sh - {1'b0, den_r}) : rem_sh[SW-1:0];
  assign q_nxt   = {q_r[GAIN_BITS-2:0], fit};
  assign gain    = den_zero_r ? '0 : q_r;

  assign stat.div_last = (step_r == STEP_BITS'(DIV_STEPS - 1));

  // Shared multiplier operands
  assign mul_a = cmd.mul_cov ? GAIN_BITS'(ONE_FIX - gain) : gain;
  assign mul_b = cmd.mul_cov ? MW'(pp_r) : mag_r;

  // Round the scaled innovation, ties away from zero, and apply it
  assign rnd_w = (prod_r + HALF) >> FRAC_BITS;
  assign xp_w  = $signed({{2{xp_r[VB-1]}}, xp_r});
  assign rnd_e = $signed({1'b0, rnd_w[MW-1:0]});
  assign x_w   = neg_r ? (xp_w - rnd_e) : (xp_w + rnd_e);

  always_comb begin
    if (x_w > SMAX_W) begin
      x_new = SMAX_W[VB-1:0];
    end else if (x_w < SMIN_W) begin
      x_new = SMIN_W[VB-1:0];
    end else begin
      x_new = x_w[VB-1:0];
    end
  end

  // Forecast covariance with saturation
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      fc_sum[c] = (cmd.clear ? '0 : SW'(cov_r[c])) + SW'(q_var);
      fc_cov[c] = (|fc_sum[c][SW-1:VB]) ? {VB{1'b1}} : fc_sum[c][VB-1:0];
    end
  end

  // Channel state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        est_r[c]  <= '0;
        cov_r[c]  <= '0;
        pest_r[c] <= '0;
        pcov_r[c] <= '0;
      end
    end else begin
      if (cmd.fcast) begin
        for (int c = 0; c < CHANNELS; c++) begin
          pest_r[c] <= cmd.clear ? '0 : est_r[c];
          pcov_r[c] <= fc_cov[c];
          if (cmd.clear) begin
            est_r[c] <= '0;
            cov_r[c] <= '0;
          end
        end
      end
      if (cmd.mul_cov) est_r[ch] <= x_new;
      if (cmd.cov_wr)  cov_r[ch] <= prod_r[FRAC_BITS +: VB];
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      obs_x_r <= in_obs_x;
      obs_y_r <= in_obs_y;
    end
    if (cmd.div_init) begin
      xp_r       <= pest_sel;
      pp_r       <= pcov_sel;
      neg_r      <= diff_u[MW-1];
      mag_r      <= diff_u[MW-1] ? (~diff_u + MW'(1)) : diff_u;
      den_r      <= SW'(pcov_sel) + SW'(r_var);
      // with no measurement noise the quotient starts at one
      q_r        <= (r_var == '0) ? GAIN_BITS'(1) : '0;
      rem_r      <= (r_var == '0) ? '0 : SW'(pcov_sel);
      den_zero_r <= (pcov_sel == '0) && (r_var == '0);
      step_r     <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      step_r <= step_r + STEP_BITS'(1);
    end
    if (cmd.mul_est || cmd.mul_cov) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.out_load) begin
      out_x_r <= cmd.out_filt ? est_r[0] : pest_r[0];
      if (CHANNELS > 1) begin
        out_y_r <= cmd.out_filt ? est_r[Y_IDX] : pest_r[Y_IDX];
      end else begin
        out_y_r <= '0;
      end
    end
  end

  assign out_est_x = out_x_r;
  assign out_est_y = out_y_r;

endmodule

### rtl/two_channel_scalar_kalman.sv
// Top level of the two-channel scalar Kalman filter.
//
// Input channel: in_valid/in_ready carry one word of in_kind, in_obs_x and
// in_obs_y. Kind forecast predicts every channel, kind filter corrects every
// channel with its observation, kind reset clears the state and forecasts;
// the unused code forecasts. Result channel: out_valid/out_ready carry one
// word of out_est_x and out_est_y per input word.
// Sequence: a forecast or reset word passes through the forecast and load
// states; a filter word runs the 16-step restoring gain divider once per
// channel, then the estimate multiply, covariance multiply and covariance
// write, before the load. A new word can be taken from the cycle after the
// result is loaded, and only while the block is idle.
// The result sits in an output register: a stalled receiver holds it there
// while the next word is accepted and processed, and only the final load waits.
// Configuration: Q at byte address 0, R at byte address 4, both unsigned Q16.16;
// write them only while the block is idle. pready is always high.
// Reset (rst_n low, synchronous) clears all channel state to zero, drops any
// pending result and sets Q to 655 and R to 1.0.
`timescale 1ns / 1ps

module two_channel_scalar_kalman #(
  parameter int CHANNELS   = tck_pkg::CHANNELS_DEF,
  parameter int VALUE_BITS = tck_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_kind,
  input  logic signed [VALUE_BITS-1:0]  in_obs_x,
  input  logic signed [VALUE_BITS-1:0]  in_obs_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_BITS-1:0]  out_est_x,
  output logic signed [VALUE_BITS-1:0]  out_est_y,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tck_pkg::ADDR_BITS-1:0] paddr,
  input  logic [tck_pkg::CFG_BITS-1:0]  pwdata,
  output logic [tck_pkg::CFG_BITS-1:0]  prdata,
  output logic                          pready
);
  import tck_pkg::*;

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  cmd_t                cmd;
  stat_t               stat;
  logic [CW-1:0]       ch;
  logic [CFG_BITS-1:0] q_var;
  logic [CFG_BITS-1:0] r_var;

  tck_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .q_var   (q_var),
    .r_var   (r_var)
  );

  tck_ctrl #(
    .CHANNELS (CHANNELS),
    .CW       (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .stat      (stat),
    .ch        (ch),
    .cmd       (cmd)
  );

  tck_dp #(
    .CHANNELS   (CHANNELS),
    .VALUE_BITS (VALUE_BITS),
    .CW         (CW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .ch        (ch),
    .in_obs_x  (in_obs_x),
    .in_obs_y  (in_obs_y),
    .q_var     (q_var),
    .r_var     (r_var),
    .out_est_x (out_est_x),
    .out_est_y (out_est_y)
  );

endmodule

### rtl/tck_checker.sv
// Port-level checks for the Kalman filter top level, bound to every instance.
`timescale 1ns / 1ps

module tck_checker #(
  parameter int VALUE_BITS = tck_pkg::VALUE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [VALUE_BITS-1:0]  out_est_x,
  input logic signed [VALUE_BITS-1:0]  out_est_y
);

  logic [1:0] pend_r;
  logic [1:0] pend_nxt;

  // Track words accepted but not yet delivered
  always_comb begin
    pend_nxt = pend_r;
    if (in_valid && in_ready)   pend_nxt = pend_nxt + 2'd1;
    if (out_valid && out_ready) pend_nxt = pend_nxt - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // The block is busy with an accepted word: ready drops after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready stayed high after an accept");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_est_x) && $stable(out_est_y)))
    else $error("stalled result changed or dropped");

  // No result without an outstanding word
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 2'd0))
    else $error("result shown with no word outstanding");

  // When ready, only the output register may hold a word
  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (pend_r == (out_valid ? 2'd1 : 2'd0)))
    else $error("word lost or duplicated while idle");

endmodule

bind two_channel_scalar_kalman tck_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_tck_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_est_x (out_est_x),
  .out_est_y (out_est_y)
);
